FILE: rtl/core/sdeq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sorted delay event queue.
package sdeq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned IDX_FIELD_W   = 10;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned TOL_W         = 16;
  localparam int unsigned OCC_W         = 5;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  // Register word index on the configuration port.
  localparam logic [PADDR_W-3:0] REG_TIE_TOLERANCE = 1'b0;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_EXTRACT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_WR,
    S_POP_HEAD,
    S_POP_CHK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] species;
    logic [IDX_FIELD_W-1:0] reaction;
    logic [TIME_W-1:0]      time_val;
  } entry_t;

  typedef struct packed {
    logic [1:0]             operation;
    logic [IDX_FIELD_W-1:0] species_index;
    logic [IDX_FIELD_W-1:0] reaction_index;
    logic [TIME_W-1:0]      delay_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   has_entry;
    logic [IDX_FIELD_W-1:0] out_species_index;
    logic [IDX_FIELD_W-1:0] out_reaction_index;
    logic [TIME_W-1:0]      out_delay_time;
    logic                   last_result;
    logic [OCC_W-1:0]       occupancy;
  } out_item_t;

endpackage

FILE: rtl/core/sdeq_ctrl.sv
`timescale 1ns / 1ps
// Queue sequencer: circular entry memory, shared compare unit, result register.
module sdeq_ctrl import sdeq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [TOL_W-1:0] tol_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned PH_W  = IDX_W + 1;
  localparam int unsigned OCX_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;
  localparam int unsigned LIM_W = TIME_W + 1;

  // logical slot -> physical address, wraps at DEPTH
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] ofs);
    logic [PH_W-1:0] sum;
    sum = PH_W'(base) + PH_W'(ofs);
    if (sum >= PH_W'(DEPTH)) begin
      sum = sum - PH_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              ext_q, ext_d;
  status_e           status_q, status_d;
  entry_t            new_q, new_d;
  entry_t            cur_q, cur_d;
  logic [LIM_W-1:0]  limit_q, limit_d;
  entry_t            rd_q;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              out_load;

  entry_t            mem [DEPTH];
  logic [IDX_W-1:0]  rlog, wlog;
  logic              we;
  entry_t            wdata;

  logic              in_fire, out_free, more, greater, full;
  logic [IDX_W-1:0]  head_inc;
  logic [CNT_W-1:0]  count_m1;
  logic [OCX_W-1:0]  occ_ext;
  logic [OCC_W-1:0]  occ;

  assign in_fire  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign greater  = rd_q.time_val > new_q.time_val;
  assign full     = count_q == CNT_W'(DEPTH);
  assign more     = ext_q && (count_q != '0) && ({1'b0, rd_q.time_val} <= limit_q);
  assign head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign count_m1 = count_q - 1'b1;
  assign occ_ext  = OCX_W'(count_q);
  assign occ      = occ_ext[OCC_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data_i.operation)
            OP_INSERT: begin
              if (full) begin
                state_d = S_RESP;
              end else if (count_q == '0) begin
                state_d = S_INS_WR;
              end else begin
                state_d = S_INS_CMP;
              end
            end
            OP_REMOVE, OP_EXTRACT: begin
              state_d = (count_q == '0) ? S_RESP : S_POP_HEAD;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_INS_CMP: begin
        if (greater) begin
          state_d = (idx_q == IDX_W'(1)) ? S_INS_WR : S_INS_CMP;
        end else begin
          state_d = S_RESP;
        end
      end
      S_INS_WR:   state_d = S_RESP;
      S_POP_HEAD: state_d = S_POP_CHK;
      S_POP_CHK: begin
        if (out_free && !more) begin
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    rlog     = '0;
    wlog     = idx_q;
    we       = 1'b0;
    wdata    = new_q;
    head_d   = head_q;
    count_d  = count_q;
    idx_d    = idx_q;
    ext_d    = ext_q;
    status_d = status_q;
    new_d    = new_q;
    cur_d    = cur_q;
    limit_d  = limit_q;
    out_load = 1'b0;
    out_d    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_data_i.operation == OP_INSERT) begin
          rlog = count_m1[IDX_W-1:0];
        end
        if (in_fire) begin
          new_d.species  = in_data_i.species_index;
          new_d.reaction = in_data_i.reaction_index;
          new_d.time_val = in_data_i.delay_time;
          ext_d          = in_data_i.operation == OP_EXTRACT;
          idx_d          = count_q[IDX_W-1:0];
          status_d       = STAT_OK;
          case (in_data_i.operation)
            OP_INSERT: begin
              if (full) begin
                status_d = STAT_FULL;
              end
            end
            OP_REMOVE, OP_EXTRACT: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end
            end
            default: status_d = STAT_OK;
          endcase
        end
      end
      S_INS_CMP: begin
        // slot idx is free; move the entry below it up or drop the new one in
        we   = 1'b1;
        rlog = idx_q - IDX_W'(2);
        if (greater) begin
          wdata = rd_q;
          idx_d = idx_q - 1'b1;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      S_INS_WR: begin
        we      = 1'b1;
        count_d = count_q + 1'b1;
      end
      S_POP_HEAD: begin
        cur_d   = rd_q;
        limit_d = {1'b0, rd_q.time_val} + LIM_W'(tol_i);
        head_d  = head_inc;
        count_d = count_m1;
        rlog    = IDX_W'(1);
      end
      S_POP_CHK: begin
        if (out_free) begin
          out_load                 = 1'b1;
          out_d.status             = STAT_OK;
          out_d.has_entry          = 1'b1;
          out_d.out_species_index  = cur_q.species;
          out_d.out_reaction_index = cur_q.reaction;
          out_d.out_delay_time     = cur_q.time_val;
          out_d.last_result        = !more;
          out_d.occupancy          = occ;
          if (more) begin
            cur_d   = rd_q;
            head_d  = head_inc;
            count_d = count_m1;
            rlog    = IDX_W'(1);
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.status      = status_q;
          out_d.last_result = 1'b1;
          out_d.occupancy   = occ;
        end
      end
      default: begin
        rlog = '0;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      ext_q       <= 1'b0;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      ext_q       <= ext_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q   <= new_d;
    cur_q   <= cur_d;
    limit_q <= limit_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[phys(head_q, wlog)] <= wdata;
    end
    rd_q <= mem[phys(head_q, rlog)];
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.operation == OP_INSERT && full)
      |=> (state_q == S_RESP && $stable(count_q) && status_q == STAT_FULL))
    else $error("insert into full queue not refused");

  a_sorted_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_CHK && more) |-> (rd_q.time_val >= cur_q.time_val))
    else $error("extracted entries out of order");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) ||
    ($past(count_q) == count_q + 1'b1))
    else $error("entry count jumped");

endmodule

FILE: rtl/core/sorted_delay_event_queue.sv
`timescale 1ns / 1ps
// Top level of the sorted delay event queue: configuration port and queue core.
//
// Usage: one input channel (in_valid_i / in_stall_o / in_data_i) takes command
// beats: insert, remove head, or extract every head entry tied with the
// minimum time. One output channel (out_valid_o / out_stall_i / out_data_o)
// gives result beats; an extract gives one beat per popped entry, with
// last_result set on the final one. Entries live in a circular memory of
// DEPTH slots; a pop just moves the head pointer.
// Timing: the sequencer handles one command at a time and stalls the input
// meanwhile. An insert walks from the tail toward the head through the shared
// time comparator, one entry per cycle, until its slot is found. Remove steps
// through the pop-head and pop-check states; an extract stays in pop-check
// for each further tied entry. Full or empty refusals go straight to S_RESP.
// The single read port of the entry memory sets that walk rate.
// Stall: results sit in one output register; the next command is taken while a
// result waits, and an extract waits in place until each beat is taken.
// Reset clears the count, head pointer and handshakes and sets tie_tolerance
// to 1; the memory needs no clearing pass. tie_tolerance is to be written over
// the APB port only while the queue is idle; the block does not enforce it.
module sorted_delay_event_queue import sdeq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  logic [TOL_W-1:0]     tol_q, tol_d;
  logic [PADDR_W-3:0]   reg_word;
  logic                 cfg_wr;

  // word-aligned register decode
  assign reg_word = paddr[PADDR_W-1:2];
  assign cfg_wr   = psel && penable && pwrite && (reg_word == REG_TIE_TOLERANCE);
  assign tol_d    = cfg_wr ? pwdata[TOL_W-1:0] : tol_q;
  assign pready   = 1'b1;
  assign prdata   = (reg_word == REG_TIE_TOLERANCE) ? PDATA_W'(tol_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else begin
      tol_q <= tol_d;
    end
  end

  sdeq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_i       (tol_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
